// ----- rtl/core/ping_pong_sample_buffer_defines.svh -----
// Assertion macros shared by the ping-pong sample buffer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PING_PONG_SAMPLE_BUFFER_DEFINES_SVH
`define PING_PONG_SAMPLE_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while in reset.
`define PPSB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ppsb assertion failed");

// Next-cycle implication, disabled while in reset.
`define PPSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ppsb assertion failed");

`else

`define PPSB_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PPSB_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/ppsb_pkg.sv -----
// Shared types and constants for the ping-pong sample buffer.
// No dependencies; imported by ppsb_ctrl, ppsb_dp and the top level.
package ppsb_pkg;

    localparam int TIME_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int ENTRY_W  = TIME_W + SAMPLE_W;

    // Command codes on the mode field; code 3 is unused and drives no bank action
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Controller -> datapath commands, at most one action set per cycle besides done
    typedef struct packed {
        logic push_a;
        logic push_b;
        logic reject;
        logic read_a;
        logic read_b;
        logic clear;
        logic done;     // any transfer accepted: load the result registers
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic a_full;
        logic b_full;
    } t_status;

endpackage

// ----- rtl/core/ppsb_ctrl.sv -----
// Controller for the ping-pong sample buffer: decodes accepted commands.
// Depends on ppsb_pkg and ping_pong_sample_buffer_defines.svh.
`include "ping_pong_sample_buffer_defines.svh"

module ppsb_ctrl
    import ppsb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_mode,
    input  t_status     i_status,
    output logic        o_busy,
    output t_cmd        o_cmd,
    output logic        o_result_valid
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_RESULT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // every command finishes in the accept cycle; never stalls the sender
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_comb begin
        o_cmd      = '0;
        o_cmd.done = w_accept;
        if (w_accept) begin
            unique case (i_mode)
                MODE_PUSH: begin
                    priority if (!i_status.a_full) begin
                        o_cmd.push_a = 1'b1;
                    end else if (!i_status.b_full) begin
                        o_cmd.push_b = 1'b1;
                    end else begin
                        o_cmd.reject = 1'b1;
                    end
                end
                MODE_READ: begin
                    priority if (i_status.a_full) begin
                        o_cmd.read_a = 1'b1;
                    end else if (i_status.b_full) begin
                        o_cmd.read_b = 1'b1;
                    end else begin
                        o_cmd.read_a = 1'b0;
                    end
                end
                MODE_CLEAR: begin
                    o_cmd.clear = 1'b1;
                end
                default: begin
                    o_cmd.clear = 1'b0;
                end
            endcase
        end
    end

    // result strobe is registered: it rises in the cycle after each accepted transfer
    always_comb begin
        n_state = w_accept ? S_RESULT : S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_result_valid = (r_state == S_RESULT);

    `PPSB_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, w_accept, o_result_valid)
    `PPSB_ASSERT_NEXT(a_no_spurious_result, i_clk, i_rst_n, !w_accept, !o_result_valid)
    `PPSB_ASSERT_NOW(a_one_action, i_clk, i_rst_n, 1'b1,
        $onehot0({o_cmd.push_a, o_cmd.push_b, o_cmd.reject, o_cmd.read_a,
                  o_cmd.read_b, o_cmd.clear}))

endmodule

// ----- rtl/core/ppsb_dp.sv -----
// Datapath for the ping-pong sample buffer: two bank memories, bank
// indices, full flags and result registers. Depends on ppsb_pkg and the defines header.
`include "ping_pong_sample_buffer_defines.svh"

module ppsb_dp
    import ppsb_pkg::*;
#(
    parameter int BANK_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic [TIME_W-1:0]          i_time_ms,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output t_status                    o_status,
    output logic                       o_push_rejected,
    output logic                       o_full_event,
    output logic                       o_read_valid,
    output logic [TIME_W-1:0]          o_read_time,
    output logic signed [SAMPLE_W-1:0] o_read_sample,
    output logic                       o_more_follow
);

    localparam int IDX_W = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BANK_DEPTH - 1);

    logic [ENTRY_W-1:0] r_mem_a [BANK_DEPTH];
    logic [ENTRY_W-1:0] r_mem_b [BANK_DEPTH];
    logic [ENTRY_W-1:0] r_rd_a;
    logic [ENTRY_W-1:0] r_rd_b;
    logic               r_rd_sel_b;

    // one index per bank: write position while filling, read position while full
    logic [IDX_W-1:0] r_a_idx, n_a_idx;
    logic [IDX_W-1:0] r_b_idx, n_b_idx;
    logic             r_a_full, n_a_full;
    logic             r_b_full, n_b_full;

    logic r_push_rejected, n_push_rejected;
    logic r_full_event, n_full_event;
    logic r_read_valid, n_read_valid;
    logic r_more_follow, n_more_follow;

    logic w_a_last;
    logic w_b_last;
    logic [ENTRY_W-1:0] w_entry;
    logic [ENTRY_W-1:0] w_rd_data;

    assign w_a_last = (r_a_idx == LAST_IDX);
    assign w_b_last = (r_b_idx == LAST_IDX);
    assign w_entry  = {i_time_ms, i_sample_value};

    always_comb begin
        n_a_idx         = r_a_idx;
        n_b_idx         = r_b_idx;
        n_a_full        = r_a_full;
        n_b_full        = r_b_full;
        n_push_rejected = r_push_rejected;
        n_full_event    = r_full_event;
        n_read_valid    = r_read_valid;
        n_more_follow   = r_more_follow;

        if (i_cmd.done) begin
            n_push_rejected = i_cmd.reject;
            n_full_event    = i_cmd.reject;
            n_read_valid    = i_cmd.read_a || i_cmd.read_b;
            n_more_follow   = 1'b0;
        end

        if (i_cmd.push_a) begin
            n_a_idx      = w_a_last ? '0 : r_a_idx + 1'b1;
            n_a_full     = w_a_last;
            n_full_event = w_a_last;
        end
        if (i_cmd.push_b) begin
            n_b_idx      = w_b_last ? '0 : r_b_idx + 1'b1;
            n_b_full     = w_b_last;
            n_full_event = w_b_last;
        end
        if (i_cmd.read_a) begin
            n_a_idx       = w_a_last ? '0 : r_a_idx + 1'b1;
            n_a_full      = !w_a_last;
            n_more_follow = !w_a_last;
        end
        if (i_cmd.read_b) begin
            n_b_idx       = w_b_last ? '0 : r_b_idx + 1'b1;
            n_b_full      = !w_b_last;
            n_more_follow = !w_b_last;
        end
        if (i_cmd.clear) begin
            n_a_idx  = '0;
            n_b_idx  = '0;
            n_a_full = 1'b0;
            n_b_full = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_idx         <= '0;
            r_b_idx         <= '0;
            r_a_full        <= 1'b0;
            r_b_full        <= 1'b0;
            r_push_rejected <= 1'b0;
            r_full_event    <= 1'b0;
            r_read_valid    <= 1'b0;
            r_more_follow   <= 1'b0;
        end else begin
            r_a_idx         <= n_a_idx;
            r_b_idx         <= n_b_idx;
            r_a_full        <= n_a_full;
            r_b_full        <= n_b_full;
            r_push_rejected <= n_push_rejected;
            r_full_event    <= n_full_event;
            r_read_valid    <= n_read_valid;
            r_more_follow   <= n_more_follow;
        end
    end

    // bank memories: one write or one read per cycle, registered read data
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_a) begin
            r_mem_a[r_a_idx] <= w_entry;
        end
        if (i_cmd.read_a) begin
            r_rd_a <= r_mem_a[r_a_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_b) begin
            r_mem_b[r_b_idx] <= w_entry;
        end
        if (i_cmd.read_b) begin
            r_rd_b <= r_mem_b[r_b_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_a || i_cmd.read_b) begin
            r_rd_sel_b <= i_cmd.read_b;
        end
    end

    assign w_rd_data = r_rd_sel_b ? r_rd_b : r_rd_a;

    assign o_status.a_full = r_a_full;
    assign o_status.b_full = r_b_full;
    assign o_push_rejected = r_push_rejected;
    assign o_full_event    = r_full_event;
    assign o_read_valid    = r_read_valid;
    assign o_more_follow   = r_more_follow;
    assign o_read_time     = r_read_valid ? w_rd_data[ENTRY_W-1:SAMPLE_W] : '0;
    assign o_read_sample   = r_read_valid ? w_rd_data[SAMPLE_W-1:0] : '0;

    `PPSB_ASSERT_NOW(a_reject_when_both_full, i_clk, i_rst_n, i_cmd.reject,
        r_a_full && r_b_full)
    `PPSB_ASSERT_NOW(a_read_b_only_after_a, i_clk, i_rst_n, i_cmd.read_b,
        r_b_full && !r_a_full)
    `PPSB_ASSERT_NOW(a_more_only_on_read, i_clk, i_rst_n, r_more_follow,
        r_read_valid && !r_full_event)

endmodule

// ----- rtl/core/ping_pong_sample_buffer.sv -----
// Top level of the ping-pong sample buffer: controller plus datapath.
// Depends on ppsb_pkg, ppsb_ctrl and ppsb_dp.
//
//  channel   handshake           payload
//  --------  ------------------  ----------------------------------------------
//  command   start / busy        i_mode, i_time_ms, i_sample_value
//  result    o_valid (strobe)    o_push_rejected, o_full_event, o_read_valid,
//                                o_read_time, o_read_sample, o_more_follow
//
// One command per cycle: a command transfer occurs at each edge with start
// high and busy low; busy never rises, since every push, read or clear
// finishes on the bank memory port in its accept cycle.
// The result shows on the result ports, with o_valid, in the cycle right
// after the transfer, for that one cycle only; the receiver cannot stall it.
// Synchronous active-low reset clears indices, full flags and the strobe.
// Bank contents are not reset; a bank becomes readable only once every
// entry of it has been written.

module ping_pong_sample_buffer
    import ppsb_pkg::*;
#(
    parameter int BANK_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_mode,
    input  logic [TIME_W-1:0]          i_time_ms,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    output logic                       o_valid,
    output logic                       o_push_rejected,
    output logic                       o_full_event,
    output logic                       o_read_valid,
    output logic [TIME_W-1:0]          o_read_time,
    output logic signed [SAMPLE_W-1:0] o_read_sample,
    output logic                       o_more_follow
);

    t_cmd    w_cmd;     // decoded action for the accepted command
    t_status w_status;  // bank full flags back to the controller

    ppsb_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_mode         (i_mode),
        .i_status       (w_status),
        .o_busy         (busy),
        .o_cmd          (w_cmd),
        .o_result_valid (o_valid)
    );

    ppsb_dp #(
        .BANK_DEPTH (BANK_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_time_ms       (i_time_ms),
        .i_sample_value  (i_sample_value),
        .o_status        (w_status),
        .o_push_rejected (o_push_rejected),
        .o_full_event    (o_full_event),
        .o_read_valid    (o_read_valid),
        .o_read_time     (o_read_time),
        .o_read_sample   (o_read_sample),
        .o_more_follow   (o_more_follow)
    );

endmodule
